### hdl/tbc_pkg.sv
// ----------------------------------------------------------------------------
// tbc_pkg
// Shared types and register indexes for the triangle transform and cull block.
// ----------------------------------------------------------------------------
`default_nettype none

package tbc_pkg;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 64;
   localparam int IO_W        = 32;

   localparam logic [CSR_INDEX_W-1:0] CSR_ROW0_C01 = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_ROW0_C23 = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_ROW1_C01 = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_ROW1_C23 = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_ROW2_C01 = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_ROW2_C23 = 3'd5;

   // one matrix row: three coefficients and the translation
   typedef struct packed {
      logic signed [IO_W-1:0] m0;
      logic signed [IO_W-1:0] m1;
      logic signed [IO_W-1:0] m2;
      logic signed [IO_W-1:0] tr;
   } tbc_row_type;

   // load enables of the three transform stages
   typedef struct packed {
      logic s1;
      logic s2;
      logic s3;
   } tbc_xf_en_type;

endpackage

`default_nettype wire

### hdl/triangle_transform_backface_cull.sv
// ----------------------------------------------------------------------------
// triangle_transform_backface_cull
// Light-space transform of a triangle with back-face culling.
// ----------------------------------------------------------------------------
// One triangle enters per clock while req_stall is low: three stages
// transform the corners (products, row sums, shift and saturate), six more
// form edges, cross product and the split dot product for the facing
// sign, and the last is the output register. Each stage holds its item only
// while the stage after it is full and stalled, so bubbles close up. A
// back-facing single-sided triangle produces no output transaction. The user
// must write matrix registers via csr only with the block empty (unchecked).
`default_nettype none

module triangle_transform_backface_cull #(
   parameter int COORD_WIDTH = 32,
   parameter int FRAC_BITS   = 16
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 csr_we,
   input  wire logic [tbc_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  wire logic [tbc_pkg::CSR_DATA_W-1:0]       csr_wdata,
   input  wire logic                                 req_valid,
   output logic                                      req_stall,
   input  wire logic signed [tbc_pkg::IO_W-1:0]      req_corner_a_x,
   input  wire logic signed [tbc_pkg::IO_W-1:0]      req_corner_a_y,
   input  wire logic signed [tbc_pkg::IO_W-1:0]      req_corner_a_z,
   input  wire logic signed [tbc_pkg::IO_W-1:0]      req_corner_b_x,
   input  wire logic signed [tbc_pkg::IO_W-1:0]      req_corner_b_y,
   input  wire logic signed [tbc_pkg::IO_W-1:0]      req_corner_b_z,
   input  wire logic signed [tbc_pkg::IO_W-1:0]      req_corner_c_x,
   input  wire logic signed [tbc_pkg::IO_W-1:0]      req_corner_c_y,
   input  wire logic signed [tbc_pkg::IO_W-1:0]      req_corner_c_z,
   input  wire logic                                 req_single_sided,
   output logic                                      rsp_valid,
   input  wire logic                                 rsp_stall,
   output logic signed [tbc_pkg::IO_W-1:0]           rsp_out_first_x,
   output logic signed [tbc_pkg::IO_W-1:0]           rsp_out_first_y,
   output logic signed [tbc_pkg::IO_W-1:0]           rsp_out_first_z,
   output logic signed [tbc_pkg::IO_W-1:0]           rsp_out_second_x,
   output logic signed [tbc_pkg::IO_W-1:0]           rsp_out_second_y,
   output logic signed [tbc_pkg::IO_W-1:0]           rsp_out_second_z,
   output logic signed [tbc_pkg::IO_W-1:0]           rsp_out_third_x,
   output logic signed [tbc_pkg::IO_W-1:0]           rsp_out_third_y,
   output logic signed [tbc_pkg::IO_W-1:0]           rsp_out_third_z,
   output logic                                      rsp_was_front_facing
);
   import tbc_pkg::*;

   localparam int CW    = COORD_WIDTH;
   localparam int EW    = CW + 1;
   localparam int PW    = 2 * EW;
   localparam int CRW   = PW + 1;
   localparam int LO_W  = CW + 2;
   localparam int HI_W  = CRW - LO_W;
   localparam int PLO_W = CW + LO_W + 1;
   localparam int PHI_W = CW + HI_W;
   localparam int DW    = CW + CRW;
   localparam int SW    = DW + 2;
   localparam int NST   = 9;

   // ---------------- configuration ----------------
   logic [CSR_DATA_W-1:0] csr_ff [6];
   tbc_row_type           row [3];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 6; i++) begin
            csr_ff[i] <= '0;
         end
      end else if (csr_we) begin
         case (csr_index)
            CSR_ROW0_C01: csr_ff[0] <= csr_wdata;
            CSR_ROW0_C23: csr_ff[1] <= csr_wdata;
            CSR_ROW1_C01: csr_ff[2] <= csr_wdata;
            CSR_ROW1_C23: csr_ff[3] <= csr_wdata;
            CSR_ROW2_C01: csr_ff[4] <= csr_wdata;
            CSR_ROW2_C23: csr_ff[5] <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      for (int r = 0; r < 3; r++) begin
         row[r].m0 = csr_ff[2*r][31:0];
         row[r].m1 = csr_ff[2*r][63:32];
         row[r].m2 = csr_ff[2*r+1][31:0];
         row[r].tr = csr_ff[2*r+1][63:32];
      end
   end

   // ---------------- flow control ----------------
   logic [NST:1] v_ff, v_in, rdy;
   logic [NST:1] ss_ff;
   logic         rdy_out;
   logic         rsp_valid_ff;

   always_comb begin
      rdy_out  = !rsp_valid_ff || !rsp_stall;
      rdy[NST] = !v_ff[NST] || rdy_out;
      for (int k = NST - 1; k >= 1; k--) begin
         rdy[k] = !v_ff[k] || rdy[k+1];
      end
      v_in[1] = req_valid;
      for (int k = 2; k <= NST; k++) begin
         v_in[k] = v_ff[k-1];
      end
   end

   assign req_stall = !rdy[1];

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         for (int k = 1; k <= NST; k++) begin
            if (rdy[k]) begin
               v_ff[k] <= v_in[k];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (rdy[1]) begin
         ss_ff[1] <= req_single_sided;
      end
      for (int k = 2; k <= NST; k++) begin
         if (rdy[k]) begin
            ss_ff[k] <= ss_ff[k-1];
         end
      end
   end

   // ---------------- transform, stages 1 to 3 ----------------
   tbc_xf_en_type           xf_en;
   logic signed [IO_W-1:0]  pos_a [3], pos_b [3], pos_c [3];
   logic signed [CW-1:0]    xf_t1 [3], xf_t2 [3], xf_t3 [3];

   assign xf_en.s1 = rdy[1];
   assign xf_en.s2 = rdy[2];
   assign xf_en.s3 = rdy[3];

   assign pos_a[0] = req_corner_a_x;
   assign pos_a[1] = req_corner_a_y;
   assign pos_a[2] = req_corner_a_z;
   assign pos_b[0] = req_corner_b_x;
   assign pos_b[1] = req_corner_b_y;
   assign pos_b[2] = req_corner_b_z;
   assign pos_c[0] = req_corner_c_x;
   assign pos_c[1] = req_corner_c_y;
   assign pos_c[2] = req_corner_c_z;

   // t1 comes from the third listed corner, t3 from the first
   tbc_xform #(.COORD_WIDTH(COORD_WIDTH), .FRAC_BITS(FRAC_BITS)) u_xform_t1 (
      .clock (clock), .en (xf_en), .row (row), .pos (pos_c), .coord (xf_t1)
   );
   tbc_xform #(.COORD_WIDTH(COORD_WIDTH), .FRAC_BITS(FRAC_BITS)) u_xform_t2 (
      .clock (clock), .en (xf_en), .row (row), .pos (pos_b), .coord (xf_t2)
   );
   tbc_xform #(.COORD_WIDTH(COORD_WIDTH), .FRAC_BITS(FRAC_BITS)) u_xform_t3 (
      .clock (clock), .en (xf_en), .row (row), .pos (pos_a), .coord (xf_t3)
   );

   // ---------------- facing test, stages 4 to 9 ----------------
   // vertex slots: 0..2 t1, 3..5 t2, 6..8 t3
   logic signed [CW-1:0]    vtx_ff [4:NST][9];
   logic signed [EW-1:0]    e1_ff [3], e2_ff [3];
   logic signed [PW-1:0]    xp_ff [6];
   logic signed [CRW-1:0]   cr_ff [3];
   logic signed [PLO_W-1:0] plo_ff [3];
   logic signed [PHI_W-1:0] phi_ff [3];
   logic signed [DW-1:0]    dk_ff [3];
   logic                    front_ff;
   logic signed [SW-1:0]    dot;

   assign dot = SW'(dk_ff[0]) + SW'(dk_ff[1]) + SW'(dk_ff[2]);

   always_ff @(posedge clock) begin
      if (rdy[4]) begin
         for (int k = 0; k < 3; k++) begin
            vtx_ff[4][k]   <= xf_t1[k];
            vtx_ff[4][3+k] <= xf_t2[k];
            vtx_ff[4][6+k] <= xf_t3[k];
            e1_ff[k] <= EW'(xf_t2[k]) - EW'(xf_t1[k]);
            e2_ff[k] <= EW'(xf_t3[k]) - EW'(xf_t2[k]);
         end
      end
      for (int s = 5; s <= NST; s++) begin
         if (rdy[s]) begin
            vtx_ff[s] <= vtx_ff[s-1];
         end
      end
      if (rdy[5]) begin
         xp_ff[0] <= e1_ff[1] * e2_ff[2];
         xp_ff[1] <= e1_ff[2] * e2_ff[1];
         xp_ff[2] <= e1_ff[2] * e2_ff[0];
         xp_ff[3] <= e1_ff[0] * e2_ff[2];
         xp_ff[4] <= e1_ff[0] * e2_ff[1];
         xp_ff[5] <= e1_ff[1] * e2_ff[0];
      end
      if (rdy[6]) begin
         for (int k = 0; k < 3; k++) begin
            cr_ff[k] <= CRW'(xp_ff[2*k]) - CRW'(xp_ff[2*k+1]);
         end
      end
      // dot term split into a low unsigned and a high signed partial product
      if (rdy[7]) begin
         for (int k = 0; k < 3; k++) begin
            plo_ff[k] <= vtx_ff[6][k] * signed'({1'b0, cr_ff[k][LO_W-1:0]});
            phi_ff[k] <= vtx_ff[6][k] * signed'(cr_ff[k][CRW-1:LO_W]);
         end
      end
      if (rdy[8]) begin
         for (int k = 0; k < 3; k++) begin
            dk_ff[k] <= (DW'(phi_ff[k]) <<< LO_W) + DW'(plo_ff[k]);
         end
      end
      // zero counts as back facing
      if (rdy[9]) begin
         front_ff <= dot[SW-1];
      end
   end

   // ---------------- output register ----------------
   logic signed [IO_W-1:0] out_ff [9];
   logic                   ff_front_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rdy_out) begin
         rsp_valid_ff <= v_ff[NST] && (front_ff || !ss_ff[NST]);
      end
   end

   always_ff @(posedge clock) begin
      if (rdy_out) begin
         ff_front_ff <= front_ff;
         for (int k = 0; k < 3; k++) begin
            if (front_ff) begin
               out_ff[k]   <= IO_W'(vtx_ff[NST][k]);
               out_ff[6+k] <= IO_W'(vtx_ff[NST][6+k]);
            end else begin
               out_ff[k]   <= IO_W'(vtx_ff[NST][6+k]);
               out_ff[6+k] <= IO_W'(vtx_ff[NST][k]);
            end
            out_ff[3+k] <= IO_W'(vtx_ff[NST][3+k]);
         end
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_was_front_facing = ff_front_ff;
   assign rsp_out_first_x      = out_ff[0];
   assign rsp_out_first_y      = out_ff[1];
   assign rsp_out_first_z      = out_ff[2];
   assign rsp_out_second_x     = out_ff[3];
   assign rsp_out_second_y     = out_ff[4];
   assign rsp_out_second_z     = out_ff[5];
   assign rsp_out_third_x      = out_ff[6];
   assign rsp_out_third_y      = out_ff[7];
   assign rsp_out_third_z      = out_ff[8];

endmodule

`default_nettype wire

### hdl/tbc_xform.sv
// ----------------------------------------------------------------------------
// tbc_xform
// Three-stage affine transform of one corner: products, row sums, then
// floor shift, translation and saturation.
// ----------------------------------------------------------------------------
`default_nettype none

module tbc_xform #(
   parameter int COORD_WIDTH = 32,
   parameter int FRAC_BITS   = 16
) (
   input  wire logic                              clock,
   input  wire tbc_pkg::tbc_xf_en_type            en,
   input  wire tbc_pkg::tbc_row_type              row [3],
   input  wire logic signed [tbc_pkg::IO_W-1:0]   pos [3],
   output logic signed [COORD_WIDTH-1:0]          coord [3]
);
   import tbc_pkg::*;

   localparam int PROD_W = 2 * IO_W;
   localparam int SUM_W  = PROD_W + 2;
   localparam int ACC_W  = SUM_W + 1;
   localparam logic signed [ACC_W-1:0] MAXV =
      (ACC_W'(1) <<< (COORD_WIDTH - 1)) - ACC_W'(1);
   localparam logic signed [ACC_W-1:0] MINV = -MAXV - ACC_W'(1);

   logic signed [PROD_W-1:0]      prod_ff [3][3];
   logic signed [SUM_W-1:0]       sum_ff  [3];
   logic signed [COORD_WIDTH-1:0] coord_ff [3];
   logic signed [COORD_WIDTH-1:0] coord_in [3];

   always_comb begin
      logic signed [SUM_W-1:0] sh;
      logic signed [ACC_W-1:0] acc;
      for (int r = 0; r < 3; r++) begin
         sh  = sum_ff[r] >>> FRAC_BITS;
         acc = ACC_W'(sh) + ACC_W'(row[r].tr);
         if (acc > MAXV) begin
            coord_in[r] = COORD_WIDTH'(MAXV);
         end else if (acc < MINV) begin
            coord_in[r] = COORD_WIDTH'(MINV);
         end else begin
            coord_in[r] = COORD_WIDTH'(acc);
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int r = 0; r < 3; r++) begin
         if (en.s1) begin
            prod_ff[r][0] <= row[r].m0 * pos[0];
            prod_ff[r][1] <= row[r].m1 * pos[1];
            prod_ff[r][2] <= row[r].m2 * pos[2];
         end
         if (en.s2) begin
            sum_ff[r] <= SUM_W'(prod_ff[r][0]) + SUM_W'(prod_ff[r][1])
                       + SUM_W'(prod_ff[r][2]);
         end
         if (en.s3) begin
            coord_ff[r] <= coord_in[r];
         end
      end
   end

   assign coord = coord_ff;

endmodule

`default_nettype wire

### hdl/tbc_checker.sv
// ----------------------------------------------------------------------------
// tbc_checker
// Port-level checks for the triangle transform and cull block.
// ----------------------------------------------------------------------------
`default_nettype none

module tbc_checker (
   input wire logic                             clock,
   input wire logic                             reset,
   input wire logic                             req_stall,
   input wire logic                             rsp_valid,
   input wire logic                             rsp_stall,
   input wire logic signed [tbc_pkg::IO_W-1:0]  rsp_out_first_x,
   input wire logic signed [tbc_pkg::IO_W-1:0]  rsp_out_third_z,
   input wire logic                             rsp_was_front_facing
);

   // empty output register means the whole pipe can move
   a_no_stall_when_out_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> !req_stall)
      else $error("input stalled with output register empty");

   a_empty_after_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("output transaction right after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("stalled output transaction dropped");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(rsp_out_first_x)
         && $stable(rsp_out_third_z) && $stable(rsp_was_front_facing))
      else $error("stalled output payload changed");

endmodule

bind triangle_transform_backface_cull tbc_checker u_tbc_checker (.*);

`default_nettype wire

### verif/tb_triangle_transform_backface_cull.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_triangle_transform_backface_cull
// Streams triangles through the light-space transform and facing test, with
// random gaps on the request side and random stalls on the response side.
// Every response is compared with a transaction-level prediction of the
// affine transform, saturation, the exact facing sign and the drop rule.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_triangle_transform_backface_cull;
   import tbc_pkg::*;

   typedef logic signed [IO_W-1:0] coord_type;
   typedef logic signed [127:0]    wide_type;

   typedef struct {
      coord_type c[9];
      bit        ss;
   } tri_type;

   typedef struct {
      coord_type v[9];
      bit        front;
   } vtx_set_type;

   typedef struct {
      tri_type     t;
      bit          typed;
      bit          drop;
      vtx_set_type ev;
   } dir_row_type;

   localparam wide_type CMAX = 128'sh7FFF_FFFF;
   localparam wide_type CMIN = ~CMAX;
   localparam int       N_DIR = 16;
   localparam int       DRAIN_CYCLES = 24;

   logic clock, reset;
   logic csr_we;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_wdata;
   logic req_valid, req_stall, req_single_sided;
   coord_type req_c[9];
   logic rsp_valid, rsp_stall, rsp_was_front_facing;
   coord_type rsp_v[9];

   logic [CSR_DATA_W-1:0] matrix_regs[6];
   vtx_set_type expected_tris[$];
   dir_row_type dir_tab[N_DIR];
   int  errs;
   bit  calm;
   string fld_names[9] = '{"out_first_x", "out_first_y", "out_first_z",
                           "out_second_x", "out_second_y", "out_second_z",
                           "out_third_x", "out_third_y", "out_third_z"};

   triangle_transform_backface_cull dut (
      .clock(clock), .reset(reset),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_corner_a_x(req_c[0]), .req_corner_a_y(req_c[1]), .req_corner_a_z(req_c[2]),
      .req_corner_b_x(req_c[3]), .req_corner_b_y(req_c[4]), .req_corner_b_z(req_c[5]),
      .req_corner_c_x(req_c[6]), .req_corner_c_y(req_c[7]), .req_corner_c_z(req_c[8]),
      .req_single_sided(req_single_sided),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_out_first_x(rsp_v[0]), .rsp_out_first_y(rsp_v[1]), .rsp_out_first_z(rsp_v[2]),
      .rsp_out_second_x(rsp_v[3]), .rsp_out_second_y(rsp_v[4]),
      .rsp_out_second_z(rsp_v[5]),
      .rsp_out_third_x(rsp_v[6]), .rsp_out_third_y(rsp_v[7]), .rsp_out_third_z(rsp_v[8]),
      .rsp_was_front_facing(rsp_was_front_facing)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      #20ms;
      $display("tb_triangle_transform_backface_cull: done, errors");
      $finish;
   end

   // one light-space coordinate: floor of the row sum, plus translation, saturated
   function automatic coord_type light_coord(int r, coord_type x, coord_type y,
                                             coord_type z);
      coord_type m0, m1, m2, tr;
      wide_type  s;
      m0 = matrix_regs[2*r][31:0];
      m1 = matrix_regs[2*r][63:32];
      m2 = matrix_regs[2*r+1][31:0];
      tr = matrix_regs[2*r+1][63:32];
      s = wide_type'(m0) * wide_type'(x) + wide_type'(m1) * wide_type'(y)
          + wide_type'(m2) * wide_type'(z);
      s = (s >>> 16) + wide_type'(tr);
      if (s > CMAX) return CMAX[31:0];
      if (s < CMIN) return CMIN[31:0];
      return s[31:0];
   endfunction

   // returns 1 when the triangle survives culling
   function automatic bit shade_triangle(tri_type t, output vtx_set_type o);
      coord_type p1[3], p2[3], p3[3];
      wide_type  e1[3], e2[3], cr[3], dot;
      for (int r = 0; r < 3; r++) begin
         p1[r] = light_coord(r, t.c[6], t.c[7], t.c[8]);
         p2[r] = light_coord(r, t.c[3], t.c[4], t.c[5]);
         p3[r] = light_coord(r, t.c[0], t.c[1], t.c[2]);
      end
      for (int k = 0; k < 3; k++) begin
         e1[k] = wide_type'(p2[k]) - wide_type'(p1[k]);
         e2[k] = wide_type'(p3[k]) - wide_type'(p2[k]);
      end
      cr[0] = e1[1] * e2[2] - e1[2] * e2[1];
      cr[1] = e1[2] * e2[0] - e1[0] * e2[2];
      cr[2] = e1[0] * e2[1] - e1[1] * e2[0];
      dot = wide_type'(p1[0]) * cr[0] + wide_type'(p1[1]) * cr[1]
            + wide_type'(p1[2]) * cr[2];
      // a zero dot counts as back facing
      o.front = dot[127];
      for (int k = 0; k < 3; k++) begin
         o.v[k]   = o.front ? p1[k] : p3[k];
         o.v[3+k] = p2[k];
         o.v[6+k] = o.front ? p3[k] : p1[k];
      end
      return o.front || !t.ss;
   endfunction

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (calm || r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic coord_type rand_coef();
      case ($urandom_range(0, 9))
         0: return $urandom;
         1: return $urandom_range(0, 1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
         default: return $urandom_range(0, 32'h3FFFF) - 32'sh20000;
      endcase
   endfunction

   function automatic coord_type rand_corner();
      case ($urandom_range(0, 7))
         0: return $urandom;
         1: return $urandom_range(0, 1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
         default: return $urandom_range(0, 32'h1FFFFF) - 32'sh100000;
      endcase
   endfunction

   task automatic write_reg(logic [CSR_INDEX_W-1:0] idx, logic [63:0] val);
      @(negedge clock);
      csr_we = 1'b1;
      csr_index = idx;
      csr_wdata = val;
      if (idx <= CSR_ROW2_C23) matrix_regs[idx] = val;
      @(negedge clock);
      csr_we = 1'b0;
   endtask

   task automatic drain_pipe();
      while (expected_tris.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic load_matrix(logic [63:0] m[6]);
      drain_pipe();
      write_reg(CSR_ROW0_C01, m[0]);
      write_reg(CSR_ROW0_C23, m[1]);
      write_reg(CSR_ROW1_C01, m[2]);
      write_reg(CSR_ROW1_C23, m[3]);
      write_reg(CSR_ROW2_C01, m[4]);
      write_reg(CSR_ROW2_C23, m[5]);
      // an index past the matrix is ignored
      write_reg(3'd6 | 3'($urandom_range(0, 1)), {$urandom, $urandom});
   endtask

   // drives one transaction; the expectation is queued when it is accepted
   task automatic send_tri(tri_type t, bit typed, bit drop, vtx_set_type ev);
      int gap;
      vtx_set_type o;
      bit keep;
      gap = pick_gap();
      if (gap != 0) begin
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid = 1'b1;
      req_c = t.c;
      req_single_sided = t.ss;
      forever begin
         @(posedge clock);
         if (!req_stall) break;
      end
      if (typed) begin
         if (!drop) expected_tris.push_back(ev);
      end else begin
         keep = shade_triangle(t, o);
         if (keep) expected_tris.push_back(o);
      end
      @(negedge clock);
   endtask

   task automatic walk_table(int first);
      for (int i = first; i < N_DIR; i++)
         send_tri(dir_tab[i].t, dir_tab[i].typed, dir_tab[i].drop, dir_tab[i].ev);
      req_valid = 1'b0;
   endtask

   always @(negedge clock) begin
      rsp_stall <= calm ? 1'b0 : ($urandom_range(0, 99) < 25) ||
                   ($urandom_range(0, 299) == 0 ? 1'b1 : 1'b0);
   end

   always @(posedge clock) begin
      vtx_set_type e;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_tris.size() == 0) begin
            $error("response transaction with nothing expected");
            errs++;
         end else begin
            e = expected_tris.pop_front();
            for (int k = 0; k < 9; k++)
               if (rsp_v[k] !== e.v[k]) begin
                  $error("%s: expected %h, got %h", fld_names[k], e.v[k], rsp_v[k]);
                  errs++;
               end
            if (rsp_was_front_facing !== e.front) begin
               $error("was_front_facing: expected %b, got %b", e.front,
                      rsp_was_front_facing);
               errs++;
            end
         end
      end
   end

   initial begin
      logic [63:0] m[6];
      tri_type t;
      vtx_set_type none;
      coord_type one, mx, mn;
      errs = 0;
      calm = 1'b0;
      one = 32'sh10000;
      mx = 32'sh7FFF_FFFF;
      mn = 32'sh8000_0000;
      reset = 1'b1;
      csr_we = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      req_valid = 1'b0;
      req_single_sided = 1'b0;
      foreach (req_c[k]) req_c[k] = '0;
      foreach (matrix_regs[k]) matrix_regs[k] = '0;
      foreach (none.v[k]) none.v[k] = '0;
      none.front = 1'b0;

      // zero matrix after reset: every corner lands on the origin, degenerate
      foreach (dir_tab[i]) begin
         dir_tab[i].typed = 1'b0;
         dir_tab[i].drop = 1'b0;
         dir_tab[i].ev = none;
         dir_tab[i].t.ss = 1'b0;
      end
      dir_tab[0].t.c = '{mx, mx, mx, mx, mx, mx, mx, mx, mx};
      dir_tab[1].t.c = '{mn, mn, mn, mn, mn, mn, mn, mn, mn};
      dir_tab[1].t.ss = 1'b1;
      dir_tab[2].t.c = '{mx, mn, 0, mn, mx, -1, 1, 0, mx};
      dir_tab[3].t.c = '{one, 0, 0, 0, one, 0, 0, 0, one};
      dir_tab[3].t.ss = 1'b1;
      for (int i = 0; i < 4; i++) begin
         dir_tab[i].typed = 1'b1;
         dir_tab[i].drop = dir_tab[i].t.ss;
      end
      // both windings, single and double sided, degenerate and extremes
      dir_tab[4].t.c  = '{one, 0, one, 0, one, one, 0, 0, one};
      dir_tab[5].t.c  = '{0, 0, one, 0, one, one, one, 0, one};
      dir_tab[6].t.c  = '{one, 0, one, 0, one, one, 0, 0, one};
      dir_tab[6].t.ss = 1'b1;
      dir_tab[7].t.c  = '{0, 0, one, 0, one, one, one, 0, one};
      dir_tab[7].t.ss = 1'b1;
      dir_tab[8].t.c  = '{one, one, one, 2*one, 2*one, 2*one, 3*one, 3*one, 3*one};
      dir_tab[9].t.c  = dir_tab[8].t.c;
      dir_tab[9].t.ss = 1'b1;
      dir_tab[10].t.c = '{mx, mx, mx, mn, mn, mn, mx, mn, mx};
      dir_tab[11].t.c = '{mn, mx, mn, mx, mn, mx, mn, mn, mx};
      dir_tab[11].t.ss = 1'b1;
      dir_tab[12].t.c = '{-one, -one, 0, one, -one, 0, 0, one, 0};
      dir_tab[13].t.c = '{0, one, 0, one, -one, 0, -one, -one, 0};
      dir_tab[14].t.c = '{-1, 1, -1, 1, -1, 1, mx, mn, -1};
      dir_tab[15].t.c = '{0, 0, 0, 0, 0, 0, 0, 0, 0};

      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      walk_table(0);
      dir_tab[0].typed = 1'b0;

      // identity with the light in front of the triangles
      m = '{64'h0000_0000_0001_0000, 64'h0000_0000_0000_0000,
            64'h0001_0000_0000_0000, 64'h0000_0000_0000_0000,
            64'h0000_0000_0000_0000, 64'hFFFD_0000_0001_0000};
      load_matrix(m);
      walk_table(4);

      // full-scale coefficients and translations so that the rows can saturate
      m = '{64'h7FFF_FFFF_8000_0000, 64'h7FFF_FFFF_7FFF_FFFF,
            64'h8000_0000_7FFF_FFFF, 64'h8000_0000_8000_0000,
            64'h7FFF_FFFF_7FFF_FFFF, 64'h8000_0000_7FFF_FFFF};
      load_matrix(m);
      walk_table(4);

      for (int ph = 0; ph < 10; ph++) begin
         calm = 1'b0;
         for (int r = 0; r < 6; r++) m[r] = {rand_coef(), rand_coef()};
         load_matrix(m);
         calm = (ph % 4 == 3);
         for (int n = 0; n < 125; n++) begin
            foreach (t.c[k]) t.c[k] = rand_corner();
            t.ss = $urandom_range(0, 1);
            send_tri(t, 1'b0, 1'b0, none);
            // now and then let the pipeline run dry before the next triangle
            if ($urandom_range(0, 99) == 0) begin
               req_valid = 1'b0;
               while (expected_tris.size() != 0) @(negedge clock);
            end
         end
         req_valid = 1'b0;
      end

      calm = 1'b0;
      drain_pipe();
      if (errs == 0)
         $display("tb_triangle_transform_backface_cull: done, clean");
      else
         $display("tb_triangle_transform_backface_cull: done, errors");
      $finish;
   end

endmodule

`default_nettype wire
